// File: hw/rtl/lph_pkg.sv
// shared types, codes and a hash helper for the linear probe hash table
package lph_pkg;

  localparam int unsigned DEFAULT_SLOTS = 1024;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_DEL_MISS  = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_value;
  } rsp_t;

  // one fnv-1a round: xor a byte in, multiply by the prime
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b & BYTE_MASK};
    return x * FNV_PRIME;
  endfunction

endpackage

// File: hw/rtl/lph_ram.sv
// generic single port ram with registered read
module lph_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hw/rtl/lph_front.sv
// front end: request intake and multi-cycle fnv-1a home slot hash
module lph_front import lph_pkg::*; #(
  parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  req_t                     req,
  input  logic                     push,
  output logic                     full,
  output logic                     job_valid,
  input  logic                     job_take,
  output req_t                     job_req,
  output logic [$clog2(SLOTS)-1:0] job_home
);
  localparam int unsigned AW = $clog2(SLOTS);

  logic        busy;
  logic [1:0]  round;
  logic [31:0] hash;
  req_t        held;
  logic        done;
  logic        out_valid;
  req_t        out_req;
  logic [AW-1:0] out_home;
  logic [7:0]  cur_byte;

  assign full = busy;
  assign cur_byte = held.key[8*round +: 8];

  // four hash rounds, one multiply each, then a one-entry hand-off register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
      out_valid <= 1'b0;
    end else begin
      if (busy && done && (!out_valid || job_take)) begin
        out_valid <= 1'b1;
      end else if (job_take) begin
        out_valid <= 1'b0;
      end
      if (push && !busy) begin
        busy <= 1'b1;
        held <= req;
        hash <= FNV_BASIS;
        round <= '0;
        done <= 1'b0;
      end else if (busy && !done) begin
        hash <= fnv_round(hash, cur_byte);
        round <= round + 2'd1;
        if (round == 2'd3) begin
          done <= 1'b1;
        end
      end else if (busy && done && (!out_valid || job_take)) begin
        out_req <= held;
        out_home <= AW'(hash % SLOTS);
        busy <= 1'b0;
        done <= 1'b0;
      end
    end
  end

  assign job_valid = out_valid;
  assign job_req = out_req;
  assign job_home = out_home;

`ifndef NO_ASSERTIONS
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("hash done without busy");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid) else $error("job taken while none ready");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full) else $error("accepted item did not block intake");
`endif
endmodule

// File: hw/rtl/lph_back.sv
// back end: probe walk over the slot stores, update and result register
module lph_back import lph_pkg::*; #(
  parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  output logic                     job_take,
  input  req_t                     job_req,
  input  logic [$clog2(SLOTS)-1:0] job_home,
  output logic                     empty,
  input  logic                     pop,
  output rsp_t                     rsp
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] idx;
  logic [CW-1:0] visits;
  req_t          cur;
  logic          rsp_valid;
  rsp_t          rsp_reg;
  rsp_t          res;

  logic          used_we, key_we, val_we;
  logic          used_wd;
  logic [AW-1:0] ram_addr;
  logic [0:0]    used_rd;
  logic [31:0]   key_rd, val_rd;
  logic          hit, last;
  logic [AW-1:0] idx_inc;

  assign ram_addr = idx;
  assign hit  = used_rd[0] && (key_rd == cur.key);
  assign last = (visits == CW'(SLOTS - 1));
  assign idx_inc = (idx == AW'(SLOTS - 1)) ? '0 : idx + AW'(1);

  always_comb begin
    used_we = 1'b0;
    used_wd = 1'b0;
    key_we  = 1'b0;
    val_we  = 1'b0;
    if (state == S_CLEAR) begin
      used_we = 1'b1;
    end else if (state == S_CHECK) begin
      if (!used_rd[0]) begin
        if (cur.kind == OP_INSERT) begin
          used_we = 1'b1;
          used_wd = 1'b1;
          key_we  = 1'b1;
          val_we  = 1'b1;
        end
      end else if (hit) begin
        if (cur.kind == OP_INSERT) begin
          val_we = 1'b1;
        end else if (cur.kind == OP_DELETE) begin
          used_we = 1'b1;
        end
      end
    end
  end

  lph_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
    .clk(clk), .we(used_we), .addr(ram_addr), .wdata(used_wd), .rdata(used_rd));
  lph_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(key_we), .addr(ram_addr), .wdata(cur.key), .rdata(key_rd));
  lph_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(val_we), .addr(ram_addr), .wdata(cur.value), .rdata(val_rd));

  assign job_take = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || pop)) begin
        rsp_valid <= 1'b1;
      end else if (pop && rsp_valid) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx_inc;
          if (idx == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            cur <= job_req;
            idx <= job_home;
            visits <= '0;
            if (job_req.kind inside {OP_INSERT, OP_SEARCH, OP_DELETE}) begin
              state <= S_READ;
            end else begin
              res <= '{status: ST_NOT_FOUND, found_value: '0};
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_DONE;
          res.found_value <= '0;
          if (!used_rd[0]) begin
            case (cur.kind)
              OP_INSERT: res.status <= ST_NEW;
              OP_SEARCH: res.status <= ST_NOT_FOUND;
              default:   res.status <= ST_DEL_MISS;
            endcase
          end else if (hit) begin
            case (cur.kind)
              OP_INSERT: res.status <= ST_UPDATED;
              OP_SEARCH: begin
                res.status <= ST_FOUND;
                res.found_value <= val_rd;
              end
              default:   res.status <= ST_DELETED;
            endcase
          end else if (last) begin
            case (cur.kind)
              OP_INSERT: res.status <= ST_FULL;
              OP_SEARCH: res.status <= ST_NOT_FOUND;
              default:   res.status <= ST_DEL_MISS;
            endcase
          end else begin
            idx <= idx_inc;
            visits <= visits + CW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          // post only once the previous result has been taken
          if (!rsp_valid || pop) begin
            rsp_reg <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !rsp_valid;
  assign rsp = rsp_reg;

`ifndef NO_ASSERTIONS
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !job_take) else $error("job taken during clear");
  a_visit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (visits <= CW'(SLOTS - 1))) else $error("probe overran");
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state) == S_READ) else $error("check without read");
`endif
endmodule

// File: hw/rtl/linear_probe_hash_table.sv
// top level of the open addressing hash table with linear probing
//
// channel  | direction | handshake       | payload
// request  | in        | push / full     | req   (kind, key, value)
// response | out       | pop / empty     | rsp   (status, found_value)
//
// a request passes through the front (load, four fnv-1a multiply rounds, hand-off)
// and through the back once per probed slot (registered ram read, compare/update),
// and then posts its result from the back's done state;
// front and back overlap, so the front can hash the next request while the back probes.
// after reset the back clears every used mark before taking work.
// an untaken result stalls the back in its done state; the front then fills its
// hash stage and hand-off register and holds full high until the back moves on.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic push,
  output logic full,
  output rsp_t rsp,
  output logic empty,
  input  logic pop
);
  // one-entry hand-off between front and back
  logic                     job_valid;
  logic                     job_take;
  req_t                     job_req;
  logic [$clog2(SLOTS)-1:0] job_home;

  lph_front #(.SLOTS(SLOTS)) u_front (
    .clk(clk), .rst(rst), .req(req), .push(push), .full(full),
    .job_valid(job_valid), .job_take(job_take), .job_req(job_req), .job_home(job_home));

  lph_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_take(job_take),
    .job_req(job_req), .job_home(job_home), .empty(empty), .pop(pop), .rsp(rsp));
endmodule

// File: dv/linear_probe_hash_table_checker.sv
// checker for the hash table: predicts each response and compares it with the transfer seen
`timescale 1ns / 100ps
module linear_probe_hash_table_checker import lph_pkg::*; #(
  parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic push,
  input  logic full,
  input  rsp_t rsp,
  input  logic empty,
  input  logic pop,
  output int   fail_count,
  output int   pending
);

  bit          used_mark [SLOTS];
  logic [31:0] key_store [SLOTS];
  logic [31:0] val_store [SLOTS];
  rsp_t        rsp_queue [$];

  function automatic int unsigned fnv_slot(logic [31:0] k);
    logic [31:0] h;
    h = 32'd2166136261;
    for (int i = 0; i < 4; i++) begin
      h = h ^ {24'd0, k[i*8 +: 8]};
      h = h * 32'd16777619;
    end
    return h % SLOTS;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    int unsigned idx;
    bit          hit;
    bit          hole;
    idx = fnv_slot(r.key);
    hit = 0;
    hole = 0;
    o.status = ST_NOT_FOUND;
    o.found_value = '0;
    if (r.kind == OP_NONE) return o;
    for (int n = 0; n < SLOTS; n++) begin
      if (!used_mark[idx]) begin
        hole = 1;
        break;
      end
      if (key_store[idx] == r.key) begin
        hit = 1;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end
    case (r.kind)
      OP_INSERT: begin
        if (hit) begin
          val_store[idx] = r.value;
          o.status = ST_UPDATED;
        end else if (hole) begin
          used_mark[idx] = 1;
          key_store[idx] = r.key;
          val_store[idx] = r.value;
          o.status = ST_NEW;
        end else o.status = ST_FULL;
      end
      OP_SEARCH: begin
        if (hit) begin
          o.status = ST_FOUND;
          o.found_value = val_store[idx];
        end
      end
      default: begin
        if (hit) begin
          used_mark[idx] = 0;
          o.status = ST_DELETED;
        end else o.status = ST_DEL_MISS;
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (used_mark[i]) used_mark[i] = 0;
      rsp_queue.delete();
      fail_count = 0;
    end else begin
      if (push && !full) rsp_queue.push_back(table_apply(req));
      if (pop && !empty) begin
        if (rsp_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response status %0d", rsp.status);
        end else begin
          want = rsp_queue.pop_front();
          if (want.status !== rsp.status || want.found_value !== rsp.found_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
                       want.status, rsp.status, want.found_value, rsp.found_value);
          end
        end
      end
    end
    pending = rsp_queue.size();
  end

endmodule

// File: dv/linear_probe_hash_table_test.sv
// top of the hash table testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module linear_probe_hash_table_test;
  import lph_pkg::*;

  localparam int unsigned SLOTS = 1024;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  req_t req;
  logic push;
  logic full;
  rsp_t rsp;
  logic empty;
  logic pop;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   stim_done;
  bit   hold_off;

  // small key pool so that probe chains, updates and deletes happen often
  logic [31:0] key_pool [64];

  linear_probe_hash_table #(.SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst), .req(req), .push(push), .full(full),
    .rsp(rsp), .empty(empty), .pop(pop)
  );

  linear_probe_hash_table_checker #(.SLOTS(SLOTS)) i_checker (
    .clk(clk), .rst(rst), .req(req), .push(push), .full(full),
    .rsp(rsp), .empty(empty), .pop(pop),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // offer one request and hold it until the transfer happens
  task automatic send_req(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
    req.kind = kind;
    req.key = key;
    req.value = value;
    push = 1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_gap();
    push = 0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  // random request mostly drawn from the pool, with some fully random keys
  task automatic send_random();
    logic [1:0]  kind;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) kind = OP_INSERT;
    else if (pick < 75) kind = OP_SEARCH;
    else if (pick < 97) kind = OP_DELETE;
    else kind = OP_NONE;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 63)];
    send_req(kind, key, $urandom());
  endtask

  // receiver: own stall pattern plus one long hold-off
  initial begin
    pop = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) pop = 0;
      else if (($urandom_range(0, 99) < 30) && !stim_done) pop = 0;
      else pop = 1;
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG + SLOTS) begin
        $display("linear_probe_hash_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    hold_off = 0;
    stim_done = 0;
    rst = 1;
    push = 0;
    req = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    repeat (2) @(negedge clk);
    rst = 0;

    // directed: extremes, every operation, the unused kind
    send_req(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_req(OP_DELETE, 32'h7fff_ffff, 32'h0);
    send_req(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(OP_INSERT, 32'h0, 32'hffff_ffff);
    send_req(OP_INSERT, 32'hffff_ffff, 32'h0);
    send_req(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_req(OP_SEARCH, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_req(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_req(OP_NONE, 32'h8000_0000, 32'hffff_ffff);
    send_req(OP_DELETE, 32'h8000_0000, 32'h0);
    send_req(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_req(OP_DELETE, 32'h8000_0000, 32'h0);
    send_req(OP_SEARCH, 32'hffff_ffff, 32'h0);
    send_req(OP_SEARCH, 32'h0, 32'h0);

    // long receiver hold-off while requests keep coming, so full rises
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (60) send_random();
    join

    for (int n = 0; n < 1550; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) send_random();
      if ($urandom_range(0, 3) != 0) send_gap();
    end
    push = 0;
    stim_done = 1;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_probe_hash_table verification clean");
    end else begin
      $display("linear_probe_hash_table verification failed");
    end
    $finish;
  end

endmodule

// File: linear_probe_hash_table.f
hw/rtl/lph_pkg.sv
hw/rtl/lph_ram.sv
hw/rtl/lph_front.sv
hw/rtl/lph_back.sv
hw/rtl/linear_probe_hash_table.sv
dv/linear_probe_hash_table_checker.sv
dv/linear_probe_hash_table_test.sv
